// ----- src/fftrp_pkg.sv -----
`timescale 1ns / 1ps

package fftrp_pkg;

  // Field widths of the job and result transactions.
  localparam int unsigned CPU_W = 16;
  localparam int unsigned MEM_W = 16;
  localparam int unsigned TAG_W = 10;
  localparam int unsigned CNT_W = 7;

  // Configuration port layout.
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_CPU_CAP   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEM_CAP   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SRV_COUNT = 2'd2;

  // Default number of server cells.
  localparam int unsigned MAX_SERVERS_DEFAULT = 64;

  // Stream widths: tdata padded up to whole bytes.
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 24;

  // Job payload that travels down the chain of server cells.
  typedef struct packed {
    logic             start;
    logic [CPU_W-1:0] cpu;
    logic [MEM_W-1:0] mem;
    logic [TAG_W-1:0] tag;
  } job_t;

endpackage

// ----- src/fftrp_cell.sv -----
`timescale 1ns / 1ps

module fftrp_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 7
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic [fftrp_pkg::CPU_W-1:0] cpu_cap,
  input  logic [fftrp_pkg::MEM_W-1:0] mem_cap,
  input  logic [fftrp_pkg::CNT_W-1:0] server_count,
  input  logic                      in_valid,
  input  fftrp_pkg::job_t           in_job,
  input  logic                      in_placed,
  input  logic [SW-1:0]             in_server,
  output logic                      out_valid,
  output fftrp_pkg::job_t           out_job,
  output logic                      out_placed,
  output logic [SW-1:0]             out_server
);
  import fftrp_pkg::*;

  localparam int unsigned CMPW = (SW > CNT_W) ? SW : CNT_W;
  localparam logic [CMPW-1:0] IDX_C = CMPW'(IDX);
  localparam logic [SW-1:0]   NUM_C = SW'(IDX + 1);

  logic [CPU_W-1:0] cpu_left_r, cpu_left_nxt, cpu_base;
  logic [MEM_W-1:0] mem_left_r, mem_left_nxt, mem_base;
  logic             valid_r;
  job_t             job_r;
  logic             placed_r;
  logic [SW-1:0]    server_r;
  logic             active;
  logic             fit;

  // Fit test against this server, after a reload when the job opens a new set.
  always_comb begin
    active       = CMPW'(server_count) > IDX_C;
    cpu_base     = in_job.start ? cpu_cap : cpu_left_r;
    mem_base     = in_job.start ? mem_cap : mem_left_r;
    fit          = active && !in_placed &&
                   (cpu_base >= in_job.cpu) && (mem_base >= in_job.mem);
    cpu_left_nxt = fit ? cpu_base - in_job.cpu : cpu_base;
    mem_left_nxt = fit ? mem_base - in_job.mem : mem_base;
  end

  // Remaining resources of this server and the token valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_left_r <= '0;
      mem_left_r <= '0;
      valid_r    <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
      if (in_valid) begin
        cpu_left_r <= cpu_left_nxt;
        mem_left_r <= mem_left_nxt;
      end
    end
  end

  // Job token handed to the next cell.
  always_ff @(posedge clk) begin
    if (adv) begin
      job_r    <= in_job;
      placed_r <= in_placed | fit;
      server_r <= fit ? NUM_C : in_server;
    end
  end

  assign out_valid  = valid_r;
  assign out_job    = job_r;
  assign out_placed = placed_r;
  assign out_server = server_r;

endmodule

// ----- src/first_fit_two_resource_packer.sv -----
`timescale 1ns / 1ps

// First-fit packer of jobs onto MAX_SERVERS identical servers, each job needing CPU and
// memory. Each server is one cell in a chain; a job moves one cell per cycle while the chain
// advances, and the first active cell whose remaining CPU and memory both cover it takes
// the job and deducts the needs. A job with start_set reloads every server to the
// configured capacities as it passes. A new job is accepted every cycle unless the chain
// is halted; its result passes through the cell chain and then the output register. The
// whole chain halts while a result waits on out_tready. Write the configuration only while
// no job is in flight.
module first_fit_two_resource_packer #(
  parameter int unsigned MAX_SERVERS = fftrp_pkg::MAX_SERVERS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Fields from bit 0: job_cpu_need[15:0], job_mem_need[31:16], job_tag[41:32], zeros.
  input  logic [fftrp_pkg::IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: start_set.
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // Fields from bit 0: server_number[6:0], servers_in_use[13:7], job_tag_out[23:14].
  output logic [fftrp_pkg::OUT_DATA_W-1:0] out_tdata,
  // Fields from bit 0: placed.
  output logic                             out_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             cfg_we,
  input  logic [fftrp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fftrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import fftrp_pkg::*;

  localparam int unsigned SW = $clog2(MAX_SERVERS + 1);

  logic [CPU_W-1:0] cpu_cap_r;
  logic [MEM_W-1:0] mem_cap_r;
  logic [CNT_W-1:0] srv_count_r;

  logic             tok_valid  [MAX_SERVERS+1];
  job_t             tok_job    [MAX_SERVERS+1];
  logic             tok_placed [MAX_SERVERS+1];
  logic [SW-1:0]    tok_server [MAX_SERVERS+1];

  logic             adv;
  logic [SW-1:0]    highest_r, highest_nxt, highest_base;
  logic             out_valid_r;
  logic             out_placed_r;
  logic [CNT_W-1:0] out_server_r;
  logic [CNT_W-1:0] out_in_use_r;
  logic [TAG_W-1:0] out_tag_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_cap_r   <= '0;
      mem_cap_r   <= '0;
      srv_count_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CPU_CAP:   cpu_cap_r   <= cfg_wdata[CPU_W-1:0];
        REG_MEM_CAP:   mem_cap_r   <= cfg_wdata[MEM_W-1:0];
        REG_SRV_COUNT: srv_count_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The chain moves whenever the output register is free or being emptied.
  // No transaction is taken while reset is held.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv && rst_n;

  // Head of the chain: unpack the incoming transaction.
  always_comb begin
    tok_valid[0]      = in_tvalid;
    tok_job[0].start  = in_tuser;
    tok_job[0].cpu    = in_tdata[CPU_W-1:0];
    tok_job[0].mem    = in_tdata[CPU_W+MEM_W-1:CPU_W];
    tok_job[0].tag    = in_tdata[CPU_W+MEM_W+TAG_W-1:CPU_W+MEM_W];
    tok_placed[0]     = 1'b0;
    tok_server[0]     = '0;
  end

  // One cell per server.
  for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
    fftrp_cell #(
      .IDX (g),
      .SW  (SW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .adv          (adv),
      .cpu_cap      (cpu_cap_r),
      .mem_cap      (mem_cap_r),
      .server_count (srv_count_r),
      .in_valid     (tok_valid[g]),
      .in_job       (tok_job[g]),
      .in_placed    (tok_placed[g]),
      .in_server    (tok_server[g]),
      .out_valid    (tok_valid[g+1]),
      .out_job      (tok_job[g+1]),
      .out_placed   (tok_placed[g+1]),
      .out_server   (tok_server[g+1])
    );
  end

  // Highest server used in the current set, updated in job order at the tail.
  always_comb begin
    highest_base = tok_job[MAX_SERVERS].start ? '0 : highest_r;
    highest_nxt  = (tok_placed[MAX_SERVERS] && (tok_server[MAX_SERVERS] > highest_base))
                   ? tok_server[MAX_SERVERS] : highest_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      highest_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= tok_valid[MAX_SERVERS];
      if (tok_valid[MAX_SERVERS]) begin
        highest_r <= highest_nxt;
      end
    end
  end

  // Output register holding the finished result transaction.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_placed_r <= tok_placed[MAX_SERVERS];
      out_server_r <= CNT_W'(tok_server[MAX_SERVERS]);
      out_in_use_r <= CNT_W'(highest_nxt);
      out_tag_r    <= tok_job[MAX_SERVERS].tag;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_placed_r;
  assign out_tdata  = {out_tag_r, out_in_use_r, out_server_r};

endmodule

// ----- sim/first_fit_two_resource_packer_test.sv -----
`timescale 1ns / 1ps

module first_fit_two_resource_packer_test;
  import fftrp_pkg::*;

  localparam int unsigned NUM_SERVERS = MAX_SERVERS_DEFAULT;
  // One register per server cell plus the output register.
  localparam int unsigned LATENCY = NUM_SERVERS + 1;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PRINT_LIMIT = 60;

  // One placement result as it leaves the block.
  typedef struct packed {
    logic             placed;
    logic [CNT_W-1:0] server;
    logic [CNT_W-1:0] in_use;
    logic [TAG_W-1:0] tag;
  } placement_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the configuration registers and the server pool.
  logic [CPU_W-1:0] cap_cpu = '0;
  logic [MEM_W-1:0] cap_mem = '0;
  logic [CNT_W-1:0] srv_count = '0;
  logic [CPU_W-1:0] cpu_free [NUM_SERVERS];
  logic [MEM_W-1:0] mem_free [NUM_SERVERS];
  logic [CNT_W-1:0] top_server = '0;

  placement_t placements_due[$];

  int unsigned error_count = 0;
  int unsigned jobs_sent = 0;
  int unsigned placements_seen = 0;
  int unsigned jobs_placed = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  first_fit_two_resource_packer #(
    .MAX_SERVERS(NUM_SERVERS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Free-running clock, 12 ns period.
  always begin
    #6;
    clk = 1'b1;
    #6;
    clk = 1'b0;
  end

  // Predict the placement of one job and update the server pool.
  function automatic placement_t place_job(input logic start, input logic [CPU_W-1:0] cpu,
                                           input logic [MEM_W-1:0] mem,
                                           input logic [TAG_W-1:0] tag);
    placement_t  res;
    int unsigned span;
    res = '0;
    res.tag = tag;
    if (start) begin
      for (int s = 0; s < NUM_SERVERS; s++) begin
        cpu_free[s] = cap_cpu;
        mem_free[s] = cap_mem;
      end
      top_server = '0;
    end
    span = (srv_count > NUM_SERVERS) ? NUM_SERVERS : srv_count;
    for (int s = 0; s < span; s++) begin
      if (!res.placed && cpu_free[s] >= cpu && mem_free[s] >= mem) begin
        cpu_free[s] = cpu_free[s] - cpu;
        mem_free[s] = mem_free[s] - mem;
        res.placed = 1'b1;
        res.server = CNT_W'(s + 1);
        if (res.server > top_server) begin
          top_server = res.server;
        end
      end
    end
    res.in_use = top_server;
    return res;
  endfunction

  // Print one mismatch line (only the first PRINT_LIMIT) and count it.
  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < PRINT_LIMIT) begin
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    error_count++;
  endtask

  // Lower the job valid and leave the input idle for the span given by the cycles argument.
  task automatic hold_off(input int unsigned cycles);
    @(negedge clk);
    in_tvalid = 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Send one job transaction and record its expected placement.
  task automatic send_job(input logic start, input logic [CPU_W-1:0] cpu,
                          input logic [MEM_W-1:0] mem, input logic [TAG_W-1:0] tag);
    if (!calm && (jobs_sent % 64) < 40 && $urandom_range(0, 5) == 0) begin
      hold_off($urandom_range(1, 11));
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = start;
    in_tdata = IN_DATA_W'({tag, mem, cpu});
    do @(posedge clk); while (!in_tready);
    placements_due.push_back(place_job(start, cpu, mem, tag));
    jobs_sent++;
  endtask

  // Stop sending and wait until every placement has come back.
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (placements_due.size() != 0) @(posedge clk);
  endtask

  // Drain, then let the chain empty before touching the registers.
  task automatic settle();
    drain();
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write one configuration register and mirror it in the shadow copy.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_CPU_CAP:   cap_cpu = value[CPU_W-1:0];
      REG_MEM_CAP:   cap_mem = value[MEM_W-1:0];
      REG_SRV_COUNT: srv_count = value[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CPU_W-1:0] cpu_cap, input logic [MEM_W-1:0] mem_cap,
                           input logic [CNT_W-1:0] count);
    write_reg(REG_CPU_CAP, cpu_cap);
    write_reg(REG_MEM_CAP, mem_cap);
    write_reg(REG_SRV_COUNT, CFG_DATA_W'(count));
  endtask

  // Registers at reset values: no server is open, and servers hold nothing until a start.
  task automatic test_power_up();
    send_job(1'b0, '0, '0, '0);
    send_job(1'b1, '0, '0, 10'd1);
    settle();
    write_reg(REG_SRV_COUNT, CFG_DATA_W'(3));
    // Zero-need job lands on server 1; anything else finds no room.
    send_job(1'b0, '0, '0, 10'd2);
    send_job(1'b0, 16'd1, '0, 10'd3);
    settle();
  endtask

  // Full capacities with a server count above the number of cells.
  task automatic test_extremes();
    write_all(16'hFFFF, 16'hFFFF, 7'd127);
    send_job(1'b1, 16'hFFFF, 16'hFFFF, 10'd1023);
    send_job(1'b0, 16'hFFFF, 16'h0000, 10'd512);
    send_job(1'b0, 16'h0000, 16'hFFFF, 10'd256);
    send_job(1'b0, 16'h0000, 16'h0000, 10'd0);
    send_job(1'b0, 16'h5555, 16'hAAAA, 10'h155);
    settle();
  endtask

  // Jobs that fit on neither server must leave the pool untouched.
  task automatic test_fit_nowhere();
    write_all(16'd100, 16'd50, 7'd2);
    send_job(1'b1, 16'd100, 16'd50, 10'd10);
    send_job(1'b0, 16'd60, 16'd10, 10'd11);
    send_job(1'b0, 16'd50, 16'd10, 10'd12);
    send_job(1'b0, 16'd10, 16'd50, 10'd13);
    send_job(1'b0, 16'd40, 16'd40, 10'd14);
    settle();
  endtask

  // New capacities written inside a set only apply from the next start.
  task automatic test_capacity_mid_set();
    write_reg(REG_CPU_CAP, 16'd7);
    write_reg(REG_MEM_CAP, 16'd9);
    send_job(1'b0, 16'd0, 16'd0, 10'd20);
    send_job(1'b0, 16'd5, 16'd5, 10'd21);
    send_job(1'b1, 16'd7, 16'd9, 10'd22);
    send_job(1'b0, 16'd1, 16'd1, 10'd23);
    settle();
  endtask

  // One random phase: configure, then a stream of sets with mostly fitting jobs.
  task automatic run_phase(input logic [CPU_W-1:0] cpu_cap, input logic [MEM_W-1:0] mem_cap,
                           input logic [CNT_W-1:0] count, input int unsigned n_jobs,
                           input int unsigned start_every, input int unsigned shft,
                           input bit pause_midway);
    int unsigned      span;
    int unsigned      sel;
    int unsigned      j;
    logic             st;
    logic [CPU_W-1:0] c;
    logic [MEM_W-1:0] m;
    write_all(cpu_cap, mem_cap, count);
    span = (count > NUM_SERVERS) ? NUM_SERVERS : count;
    for (int unsigned i = 0; i < n_jobs; i++) begin
      st = (i == 0) || ($urandom_range(1, start_every) == 1);
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        // Noise over the whole field range.
        c = CPU_W'($urandom());
        m = MEM_W'($urandom());
      end else if (sel < 12) begin
        c = ($urandom_range(0, 1) == 0) ? '0 : CPU_W'($urandom_range(0, cpu_cap));
        m = (c != 0) ? '0 : MEM_W'($urandom_range(0, mem_cap));
      end else if (sel < 28 && span > 0) begin
        // Ask for exactly what one server has left, sometimes one unit more.
        j = $urandom_range(0, span - 1);
        c = cpu_free[j];
        m = mem_free[j];
        case ($urandom_range(0, 3))
          0: c = c + 1'b1;
          1: m = m + 1'b1;
          default: ;
        endcase
      end else begin
        c = CPU_W'($urandom_range(0, cpu_cap >> shft));
        m = MEM_W'($urandom_range(0, mem_cap >> shft));
      end
      send_job(st, c, m, TAG_W'($urandom()));
      if (pause_midway && i == n_jobs / 2) begin
        drain();
      end
    end
    settle();
  endtask

  task automatic test_random_mix();
    run_phase(16'hFFFF, 16'hFFFF, 7'd64, 200, 60, 3, 1'b0);
    run_phase(16'd1000, 16'd3000, 7'd8, 200, 25, 2, 1'b1);
    run_phase(16'd0, 16'd0, 7'd16, 120, 10, 2, 1'b0);
    run_phase(CPU_W'($urandom()), MEM_W'($urandom()), CNT_W'($urandom_range(1, 64)),
              200, 40, 2, 1'b0);
    // More servers asked for than exist: sets run long enough to fill every cell.
    run_phase(16'd500, 16'hFFFF, 7'd127, 250, 150, 0, 1'b0);
    run_phase(16'hFFFF, 16'd7, 7'd1, 150, 20, 2, 1'b0);
    run_phase(CPU_W'($urandom()), MEM_W'($urandom()), 7'd0, 60, 10, 2, 1'b0);
    run_phase(CPU_W'($urandom()), MEM_W'($urandom()), 7'd64, 250, 80, 1, 1'b0);
    // Final stretch at full rate on both sides.
    calm = 1'b1;
    run_phase(16'h8000, 16'h7FFF, 7'd33, 250, 50, 2, 1'b0);
    run_phase(CPU_W'($urandom()), MEM_W'($urandom()), CNT_W'($urandom_range(1, 127)),
              200, 30, 2, 1'b0);
  endtask

  // Main sequence.
  initial begin
    for (int s = 0; s < NUM_SERVERS; s++) begin
      cpu_free[s] = '0;
      mem_free[s] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_power_up();
    test_extremes();
    test_fit_nowhere();
    test_capacity_mid_set();
    test_random_mix();
    $display("Sent %0d jobs; checked %0d placements, %0d placed and %0d turned away.",
             jobs_sent, placements_seen, jobs_placed, placements_seen - jobs_placed);
    $display("Covered reset state, zero and full capacities, server counts 0 to 127, %s",
             "exact-fit edges and stalls on both sides.");
    if (error_count == 0) begin
      $display("first_fit_two_resource_packer_test: clean");
    end else begin
      $display("first_fit_two_resource_packer_test: errors");
    end
    $finish;
  end

  // Result side back-pressure: stall bursts, short runs and long open stretches.
  always begin : ready_pattern
    int unsigned len;
    @(negedge clk);
    len = 1;
    if (calm) begin
      out_tready = 1'b1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_tready = 1'b0;
          len = $urandom_range(1, 11);
        end
        9: begin
          out_tready = 1'b1;
          len = $urandom_range(30, 120);
        end
        default: begin
          out_tready = 1'b1;
          len = $urandom_range(1, 8);
        end
      endcase
    end
    repeat (len - 1) @(negedge clk);
  end

  // Compare each result transaction with the oldest expected placement.
  always @(posedge clk) begin : result_check
    placement_t got;
    placement_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.placed = out_tuser;
      got.server = out_tdata[6:0];
      got.in_use = out_tdata[13:7];
      got.tag = out_tdata[23:14];
      if (placements_due.size() == 0) begin
        report_mismatch("result with no job pending, tag", 32'(got.tag), 0);
      end else begin
        want = placements_due.pop_front();
        placements_seen++;
        if (want.placed) begin
          jobs_placed++;
        end
        if (got.placed !== want.placed) begin
          report_mismatch("placed", 32'(got.placed), 32'(want.placed));
        end
        if (got.server !== want.server) begin
          report_mismatch("server_number", 32'(got.server), 32'(want.server));
        end
        if (got.in_use !== want.in_use) begin
          report_mismatch("servers_in_use", 32'(got.in_use), 32'(want.in_use));
        end
        if (got.tag !== want.tag) begin
          report_mismatch("job_tag_out", 32'(got.tag), 32'(want.tag));
        end
      end
    end
  end

  // End the run if no transaction and no register write happens for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: %0d cycles without a transaction, %0d results outstanding.",
               quiet_cycles, placements_due.size());
      $display("first_fit_two_resource_packer_test: errors");
      $finish;
    end
  end

endmodule
